@@ rtl/averaging_meter_led_scanner_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef AVERAGING_METER_LED_SCANNER_MACROS_SVH
`define AVERAGING_METER_LED_SCANNER_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define AMLS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("amls assertion failed");

// Next-cycle implication, disabled while reset is active.
`define AMLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("amls assertion failed");

`endif

@@ rtl/amls_pkg.sv @@
package amls_pkg;

	localparam int AVG_COUNT   = 64;
	localparam int CYCLE_LEN   = 2 * AVG_COUNT;
	localparam int AVG_SHIFT   = $clog2(AVG_COUNT);
	localparam int CNT_W       = $clog2(CYCLE_LEN);
	localparam int SAMPLE_W    = 10;
	localparam int ACC_W       = 16;
	localparam int AVG_W       = 10;
	localparam int DISP_W      = AVG_W + 3;   // average times 8
	localparam int NUM_DIGITS  = 8;
	localparam int PTR_W       = $clog2(NUM_DIGITS);
	localparam int SEG_W       = 8;
	localparam int WORD_W      = 2 * SEG_W;
	localparam int RECIP_SHIFT = 23;
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam int PROD_W      = DISP_W + RECIP_W;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 1;

	localparam logic [SEG_W-1:0]   DOT_SEGMENT = 8'h80;
	localparam logic [RECIP_W-1:0] RECIP_DIV10 = 24'd838861;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INV_STROBES  = 1'b0,
		CFG_INV_SEGMENTS = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] adc_sample;
	} in_item_t;

	typedef struct packed {
		logic [WORD_W-1:0] drive_word;
		logic              next_channel;
		logic [AVG_W-1:0]  voltage_average;
		logic [AVG_W-1:0]  current_average;
	} out_item_t;

	typedef struct packed {
		logic [AVG_W-1:0] volt;
		logic [AVG_W-1:0] curr;
	} avg_pair_t;

	typedef struct packed {
		avg_pair_t held;          // averages before this tick's update
		avg_pair_t fresh;         // averages after this tick's update
		logic      next_channel;
	} avg_status_t;

	function automatic logic [SEG_W-1:0] seg_font(input logic [3:0] digit);
		logic [SEG_W-1:0] seg;
		case (digit)
			4'd0:    seg = 8'b00111111;
			4'd1:    seg = 8'b00000110;
			4'd2:    seg = 8'b01011011;
			4'd3:    seg = 8'b01001111;
			4'd4:    seg = 8'b01100110;
			4'd5:    seg = 8'b01101101;
			4'd6:    seg = 8'b01111101;
			4'd7:    seg = 8'b00000111;
			4'd8:    seg = 8'b01111111;
			4'd9:    seg = 8'b01101111;
			default: seg = 8'b00000000;
		endcase
		return seg;
	endfunction

	// Reciprocal of 10^place scaled by 2^RECIP_SHIFT, rounded up; exact for DISP_W-bit values.
	function automatic logic [RECIP_W-1:0] place_recip(input logic [1:0] place);
		logic [RECIP_W-1:0] r;
		case (place)
			2'd0:    r = 24'd8388608;
			2'd1:    r = 24'd838861;
			2'd2:    r = 24'd83887;
			2'd3:    r = 24'd8389;
			default: r = 24'd8388608;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/amls_chan_if.sv @@
interface amls_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/amls_avg.sv @@
module amls_avg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic [amls_pkg::SAMPLE_W-1:0] sample,
	output amls_pkg::avg_status_t         status
);
	import amls_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;
	logic [ACC_W-1:0] acc0_q;
	logic [ACC_W-1:0] acc1_q;
	logic [ACC_W-1:0] base0;
	logic [ACC_W-1:0] base1;
	logic [ACC_W-1:0] sample_ext;
	avg_pair_t        avg_q;
	avg_pair_t        avg_new;
	logic             wrap;
	logic             chan;

	always_comb begin
		wrap       = (count_q == CNT_W'(CYCLE_LEN - 1));
		count_next = wrap ? '0 : count_q + 1'b1;
		chan       = ~count_next[0];
		sample_ext = ACC_W'(sample);
		if (wrap) begin
			avg_new.volt = AVG_W'(acc0_q >> AVG_SHIFT);
			avg_new.curr = AVG_W'(acc1_q >> AVG_SHIFT);
			base0        = '0;
			base1        = '0;
		end else begin
			avg_new = avg_q;
			base0   = acc0_q;
			base1   = acc1_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			acc0_q  <= '0;
			acc1_q  <= '0;
			avg_q   <= '0;
		end else if (en) begin
			count_q <= count_next;
			avg_q   <= avg_new;
			acc0_q  <= chan ? base0 : base0 + sample_ext;
			acc1_q  <= chan ? base1 + sample_ext : base1;
		end
	end

	assign status.held         = avg_q;
	assign status.fresh        = avg_new;
	assign status.next_channel = chan;

endmodule

@@ rtl/averaging_meter_led_scanner.sv @@
// Channel      Modport  Payload                                       Moves
// sample_ch    sink     adc_sample                                    one tick per transfer
// drive_ch     source   drive_word, next_channel, voltage_average,    one result per tick
//                       current_average
// cfg_*        write    cfg_index selects invert_strobes / invert_segments
//
// One tick is taken per cycle while the output is not stalled; its result passes
// through stage 1 (captured at the transfer edge), the place divide into stage 2
// and the digit extract into the output register.
// The two reciprocal multipliers set the per-stage depth.
// Reset clears counter, accumulators, averages, scan pointer and pipeline valids.
// A stalled output freezes the whole pipeline; ready follows the output register.
module averaging_meter_led_scanner (
	input  logic                            clk,
	input  logic                            arst_n,
	amls_chan_if.sink                       sample_ch,
	amls_chan_if.source                     drive_ch,
	input  logic                            cfg_we,
	input  logic [amls_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [amls_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import amls_pkg::*;
	`include "averaging_meter_led_scanner_macros.svh"

	logic             inv_strobes_q;
	logic             inv_segments_q;
	logic [PTR_W-1:0] ptr_q;
	logic             adv;
	logic             fire;
	avg_status_t      avg_status;

	logic             valid_s1;
	logic [DISP_W-1:0] value_s1;
	logic [1:0]       place_s1;
	logic [SEG_W-1:0] mask_s1;
	logic             dot_s1;
	logic             chan_s1;
	avg_pair_t        avgs_s1;

	logic             valid_s2;
	logic [DISP_W-1:0] quot_s2;
	logic [SEG_W-1:0] mask_s2;
	logic             dot_s2;
	logic             chan_s2;
	avg_pair_t        avgs_s2;

	logic             out_valid_q;
	out_item_t        out_q;

	logic [PROD_W-1:0] place_prod;
	logic [PROD_W-1:0] div10_prod;
	logic [DISP_W-1:0] tens;
	logic [DISP_W-1:0] digit_rem;
	logic [SEG_W-1:0]  seg;
	logic [AVG_W-1:0]  shown_avg;

	assign adv             = !out_valid_q || drive_ch.ready;
	assign sample_ch.ready = adv;
	assign fire            = sample_ch.valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_strobes_q  <= 1'b0;
			inv_segments_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_INV_STROBES:  inv_strobes_q  <= cfg_wdata[0];
				CFG_INV_SEGMENTS: inv_segments_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	amls_avg u_avg (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (fire),
		.sample (sample_ch.data.adc_sample),
		.status (avg_status)
	);

	// Scan pointer: digit mask is always one-hot at the pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (fire) begin
			ptr_q <= ptr_q + 1'b1;
		end
	end

	assign shown_avg = ptr_q[PTR_W-1] ? avg_status.held.curr : avg_status.held.volt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= fire;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	// Stage 1: capture the scaled average to show and the tick's averaging results.
	always_ff @(posedge clk) begin
		if (adv) begin
			value_s1 <= {shown_avg, 3'b000};
			place_s1 <= ~ptr_q[1:0];
			mask_s1  <= SEG_W'(1) << ptr_q;
			dot_s1   <= (ptr_q == PTR_W'(1)) || (ptr_q == PTR_W'(4));
			chan_s1  <= avg_status.next_channel;
			avgs_s1  <= avg_status.fresh;
		end
	end

	// Stage 2: divide by the decimal place weight.
	assign place_prod = PROD_W'(value_s1) * PROD_W'(place_recip(place_s1));

	always_ff @(posedge clk) begin
		if (adv) begin
			quot_s2 <= DISP_W'(place_prod >> RECIP_SHIFT);
			mask_s2 <= mask_s1;
			dot_s2  <= dot_s1;
			chan_s2 <= chan_s1;
			avgs_s2 <= avgs_s1;
		end
	end

	// Output stage: take the low decimal digit, map to segments, apply inversions.
	always_comb begin
		div10_prod = PROD_W'(quot_s2) * PROD_W'(RECIP_DIV10);
		tens       = DISP_W'(div10_prod >> RECIP_SHIFT);
		digit_rem  = quot_s2 - ((tens << 3) + (tens << 1));
		seg        = seg_font(digit_rem[3:0]) | (dot_s2 ? DOT_SEGMENT : '0);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.drive_word      <= {mask_s2 ^ {SEG_W{inv_strobes_q}},
				seg ^ {SEG_W{inv_segments_q}}};
			out_q.next_channel    <= chan_s2;
			out_q.voltage_average <= avgs_s2.volt;
			out_q.current_average <= avgs_s2.curr;
		end
	end

	assign drive_ch.valid = out_valid_q;
	assign drive_ch.data  = out_q;

	`AMLS_ASSERT_NEXT(a_fire_fills_s1, clk, arst_n, fire, valid_s1)
	`AMLS_ASSERT_IMPL(a_digit_decimal, clk, arst_n, valid_s2, digit_rem < DISP_W'(10))
	`AMLS_ASSERT_IMPL(a_strobe_onehot, clk, arst_n, valid_s2, $onehot(mask_s2))

endmodule
